// File: rtl/alls_pkg.sv
// ----------------------------------------------------------------------------
// alls_pkg
// Shared codes, port widths and structs for the array linked list store.
// ----------------------------------------------------------------------------
package alls_pkg;

  localparam int POS_W     = 7;
  localparam int IN_VAL_W  = 32;
  localparam int STAT_W    = 3;
  localparam int REM_VAL_W = 32;
  localparam int FOUND_W   = 6;
  localparam int CNT_OUT_W = 7;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_SEARCH = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_e;

  localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
  localparam logic [STAT_W-1:0] ST_FULL     = 3'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd2;
  localparam logic [STAT_W-1:0] ST_BADPOS   = 3'd3;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd4;

  typedef struct packed {
    logic pop;
    logic push;
    logic clear;
  } fifo_req_t;

  typedef struct packed {
    logic [STAT_W-1:0]    status;
    logic [REM_VAL_W-1:0] removed_value;
    logic [FOUND_W-1:0]   found_position;
    logic [CNT_OUT_W-1:0] item_count;
  } result_t;

endpackage

// File: rtl/array_linked_list_store.sv
// ----------------------------------------------------------------------------
// array_linked_list_store
// Singly linked list in a slot array with a circular queue of free slots.
// Clear, rejected commands and insert at position 0 need no link walk; insert
// at position p > 0 walks the links, then writes the new node; remove walks
// to position p and search walks until a match or the end of the list. One
// command at a time: the input stalls until the output register takes the
// result. The link walk reads one link per cycle. Async reset empties the
// list and restores the free queue order; the node memory is not cleared.
// ----------------------------------------------------------------------------
module array_linked_list_store #(
  parameter int SLOTS      = 64,
  parameter int VALUE_BITS = 32
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic [1:0]                            command_i,
  input  logic [alls_pkg::POS_W-1:0]            position_i,
  input  logic signed [alls_pkg::IN_VAL_W-1:0]  item_value_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic [alls_pkg::STAT_W-1:0]           status_o,
  output logic signed [alls_pkg::REM_VAL_W-1:0] removed_value_o,
  output logic [alls_pkg::FOUND_W-1:0]          found_position_o,
  output logic [alls_pkg::CNT_OUT_W-1:0]        item_count_o
);

  import alls_pkg::*;

  localparam int SLOT_W = $clog2(SLOTS);
  localparam int NODE_W = VALUE_BITS + $clog2(SLOTS + 1);

  logic              node_we;
  logic [SLOT_W-1:0] node_waddr;
  logic [NODE_W-1:0] node_wdata;
  logic [SLOT_W-1:0] node_raddr;
  logic [NODE_W-1:0] node_rdata;
  fifo_req_t         fifo_req;
  logic [SLOT_W-1:0] fifo_push_slot;
  logic [SLOT_W-1:0] fifo_slot;
  logic              res_valid;
  logic              out_free;
  result_t           res;
  result_t           out_res_q;
  logic              out_valid_q;

  alls_ctrl #(
    .SLOTS      (SLOTS),
    .VALUE_BITS (VALUE_BITS)
  ) u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .command_i        (command_i),
    .position_i       (position_i),
    .item_value_i     (item_value_i),
    .res_valid_o      (res_valid),
    .res_ready_i      (out_free),
    .res_o            (res),
    .node_we_o        (node_we),
    .node_waddr_o     (node_waddr),
    .node_wdata_o     (node_wdata),
    .node_raddr_o     (node_raddr),
    .node_rdata_i     (node_rdata),
    .fifo_req_o       (fifo_req),
    .fifo_push_slot_o (fifo_push_slot),
    .fifo_slot_i      (fifo_slot)
  );

  alls_node_mem #(
    .SLOTS (SLOTS),
    .WIDTH (NODE_W)
  ) u_node_mem (
    .clk_i   (clk_i),
    .we_i    (node_we),
    .waddr_i (node_waddr),
    .wdata_i (node_wdata),
    .raddr_i (node_raddr),
    .rdata_o (node_rdata)
  );

  alls_free_fifo #(
    .SLOTS (SLOTS)
  ) u_free_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (fifo_req),
    .push_slot_i (fifo_push_slot),
    .slot_o      (fifo_slot)
  );

  // output register, refilled when empty or when its transfer completes
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && out_free) begin
      out_res_q <= res;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = out_res_q.status;
  assign removed_value_o  = out_res_q.removed_value;
  assign found_position_o = out_res_q.found_position;
  assign item_count_o     = out_res_q.item_count;

endmodule

// File: rtl/alls_node_mem.sv
// ----------------------------------------------------------------------------
// alls_node_mem
// Node memory: one word per slot holding value and next link, one write
// port and one read port with registered read data.
// ----------------------------------------------------------------------------
module alls_node_mem #(
  parameter int SLOTS = 64,
  parameter int WIDTH = 39
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(SLOTS)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(SLOTS)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [SLOTS];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/alls_free_fifo.sv
// ----------------------------------------------------------------------------
// alls_free_fifo
// Circular queue of free slot numbers. Entries not yet written since reset
// or clear read as their own index, tracked by the write pointer and a wrap
// flag.
// ----------------------------------------------------------------------------
module alls_free_fifo #(
  parameter int SLOTS = 64
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  alls_pkg::fifo_req_t      req_i,
  input  logic [$clog2(SLOTS)-1:0] push_slot_i,
  output logic [$clog2(SLOTS)-1:0] slot_o
);

  import alls_pkg::*;

  localparam int SLOT_W = $clog2(SLOTS);
  localparam logic [SLOT_W-1:0] LAST = SLOT_W'(SLOTS - 1);

  logic [SLOT_W-1:0] mem [SLOTS];
  logic [SLOT_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [SLOT_W-1:0] wr_ptr_q, wr_ptr_d;
  logic              wrapped_q, wrapped_d;
  logic              rd_written_q, rd_written_d;
  logic [SLOT_W-1:0] rd_data_q;
  logic [SLOT_W-1:0] rd_idx_q;

  always_comb begin
    rd_ptr_d     = rd_ptr_q;
    wr_ptr_d     = wr_ptr_q;
    wrapped_d    = wrapped_q;
    rd_written_d = wrapped_q || (rd_ptr_q < wr_ptr_q);
    if (req_i.clear) begin
      rd_ptr_d     = '0;
      wr_ptr_d     = '0;
      wrapped_d    = 1'b0;
      rd_written_d = 1'b0;
    end else begin
      if (req_i.pop) begin
        rd_ptr_d = (rd_ptr_q == LAST) ? '0 : rd_ptr_q + SLOT_W'(1);
      end
      if (req_i.push) begin
        wr_ptr_d = (wr_ptr_q == LAST) ? '0 : wr_ptr_q + SLOT_W'(1);
        if (wr_ptr_q == LAST) begin
          wrapped_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q     <= '0;
      wr_ptr_q     <= '0;
      wrapped_q    <= 1'b0;
      rd_written_q <= 1'b0;
    end else begin
      rd_ptr_q     <= rd_ptr_d;
      wr_ptr_q     <= wr_ptr_d;
      wrapped_q    <= wrapped_d;
      rd_written_q <= rd_written_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.push) begin
      mem[wr_ptr_q] <= push_slot_i;
    end
    rd_data_q <= mem[rd_ptr_q];
    rd_idx_q  <= rd_ptr_q;
  end

  assign slot_o = rd_written_q ? rd_data_q : rd_idx_q;

endmodule

// File: rtl/alls_ctrl.sv
// ----------------------------------------------------------------------------
// alls_ctrl
// Command sequencer: checks each command, walks the links through the node
// memory one slot per cycle and writes back the relinked nodes.
// ----------------------------------------------------------------------------
module alls_ctrl #(
  parameter int SLOTS      = 64,
  parameter int VALUE_BITS = 32
) (
  input  logic                                            clk_i,
  input  logic                                            rst_ni,
  input  logic                                            in_valid_i,
  output logic                                            in_stall_o,
  input  logic [1:0]                                      command_i,
  input  logic [alls_pkg::POS_W-1:0]                      position_i,
  input  logic signed [alls_pkg::IN_VAL_W-1:0]            item_value_i,
  output logic                                            res_valid_o,
  input  logic                                            res_ready_i,
  output alls_pkg::result_t                               res_o,
  output logic                                            node_we_o,
  output logic [$clog2(SLOTS)-1:0]                        node_waddr_o,
  output logic [VALUE_BITS+$clog2(SLOTS+1)-1:0]           node_wdata_o,
  output logic [$clog2(SLOTS)-1:0]                        node_raddr_o,
  input  logic [VALUE_BITS+$clog2(SLOTS+1)-1:0]           node_rdata_i,
  output alls_pkg::fifo_req_t                             fifo_req_o,
  output logic [$clog2(SLOTS)-1:0]                        fifo_push_slot_o,
  input  logic [$clog2(SLOTS)-1:0]                        fifo_slot_i
);

  import alls_pkg::*;

  localparam int SLOT_W = $clog2(SLOTS);
  localparam int LNK_W  = $clog2(SLOTS + 1);
  localparam int CNT_W  = LNK_W;
  localparam int NODE_W = VALUE_BITS + LNK_W;
  localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam logic [LNK_W-1:0] NULL_LNK = LNK_W'(SLOTS);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(SLOTS);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_WALK   = 3'd1;
  localparam logic [2:0] S_LINK   = 3'd2;
  localparam logic [2:0] S_SEARCH = 3'd3;
  localparam logic [2:0] S_DONE   = 3'd4;

  logic [2:0]            state_q, state_d;
  logic [LNK_W-1:0]      head_q, head_d;
  logic [CNT_W-1:0]      count_q, count_d;
  cmd_e                  cmd_q, cmd_d;
  logic [LNK_W-1:0]      cur_q, cur_d;
  logic [LNK_W-1:0]      prev_q, prev_d;
  logic [VALUE_BITS-1:0] prev_val_q, prev_val_d;
  logic [CMP_W-1:0]      rem_q, rem_d;
  logic [SLOT_W-1:0]     slot_q, slot_d;
  logic [LNK_W-1:0]      link_q, link_d;
  logic [VALUE_BITS-1:0] val_q, val_d;
  logic [STAT_W-1:0]     status_q, status_d;
  logic [REM_VAL_W-1:0]  removed_q, removed_d;
  logic [CNT_W-1:0]      found_q, found_d;

  logic [VALUE_BITS-1:0] in_val;
  logic [CMP_W-1:0]      pos_x;
  logic [CMP_W-1:0]      cnt_x;
  logic [VALUE_BITS-1:0] rd_val;
  logic [LNK_W-1:0]      rd_link;

  assign in_val  = VALUE_BITS'($unsigned(item_value_i));
  assign pos_x   = CMP_W'(position_i);
  assign cnt_x   = CMP_W'(count_q);
  assign rd_val  = node_rdata_i[NODE_W-1:LNK_W];
  assign rd_link = node_rdata_i[LNK_W-1:0];

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d          = state_q;
    head_d           = head_q;
    count_d          = count_q;
    cmd_d            = cmd_q;
    cur_d            = cur_q;
    prev_d           = prev_q;
    prev_val_d       = prev_val_q;
    rem_d            = rem_q;
    slot_d           = slot_q;
    link_d           = link_q;
    val_d            = val_q;
    status_d         = status_q;
    removed_d        = removed_q;
    found_d          = found_q;
    node_we_o        = 1'b0;
    node_waddr_o     = cur_q[SLOT_W-1:0];
    node_wdata_o     = '0;
    node_raddr_o     = cur_q[SLOT_W-1:0];
    fifo_req_o       = '0;
    fifo_push_slot_o = cur_q[SLOT_W-1:0];
    res_valid_o      = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_d        = cmd_e'(command_i);
          val_d        = in_val;
          removed_d    = '0;
          found_d      = '0;
          status_d     = ST_OK;
          cur_d        = head_q;
          prev_d       = NULL_LNK;
          slot_d       = fifo_slot_i;
          node_raddr_o = head_q[SLOT_W-1:0];
          state_d      = S_DONE;
          unique case (cmd_e'(command_i))
            CMD_INSERT: begin
              priority if (count_q == FULL_CNT) begin
                status_d = ST_FULL;
              end else if (pos_x > cnt_x) begin
                status_d = ST_BADPOS;
              end else if (count_q == '0 || pos_x == '0) begin
                // new head: link to the old head, null on an empty list
                node_we_o      = 1'b1;
                node_waddr_o   = fifo_slot_i;
                node_wdata_o   = {in_val, head_q};
                head_d         = LNK_W'(fifo_slot_i);
                fifo_req_o.pop = 1'b1;
                count_d        = count_q + CNT_W'(1);
              end else begin
                rem_d   = pos_x - CMP_W'(1);
                state_d = S_WALK;
              end
            end
            CMD_REMOVE: begin
              priority if (count_q == '0) begin
                status_d = ST_EMPTY;
              end else if (pos_x >= cnt_x) begin
                status_d = ST_BADPOS;
              end else begin
                rem_d   = pos_x;
                state_d = S_WALK;
              end
            end
            CMD_SEARCH: begin
              if (count_q == '0) begin
                status_d = ST_NOTFOUND;
              end else begin
                state_d = S_SEARCH;
              end
            end
            CMD_CLEAR: begin
              head_d           = NULL_LNK;
              count_d          = '0;
              fifo_req_o.clear = 1'b1;
            end
          endcase
        end
      end
      S_WALK: begin
        priority if (rem_q != '0) begin
          prev_d       = cur_q;
          prev_val_d   = rd_val;
          cur_d        = rd_link;
          node_raddr_o = rd_link[SLOT_W-1:0];
          rem_d        = rem_q - CMP_W'(1);
        end else if (cmd_q == CMD_INSERT) begin
          // predecessor now points at the new slot
          node_we_o    = 1'b1;
          node_waddr_o = cur_q[SLOT_W-1:0];
          node_wdata_o = {rd_val, LNK_W'(slot_q)};
          link_d       = rd_link;
          state_d      = S_LINK;
        end else begin
          removed_d = REM_VAL_W'(rd_val);
          if (prev_q == NULL_LNK) begin
            head_d = rd_link;
          end else begin
            node_we_o    = 1'b1;
            node_waddr_o = prev_q[SLOT_W-1:0];
            node_wdata_o = {prev_val_q, rd_link};
          end
          fifo_req_o.push  = 1'b1;
          fifo_push_slot_o = cur_q[SLOT_W-1:0];
          count_d          = count_q - CNT_W'(1);
          state_d          = S_DONE;
        end
      end
      S_LINK: begin
        node_we_o      = 1'b1;
        node_waddr_o   = slot_q;
        node_wdata_o   = {val_q, link_q};
        fifo_req_o.pop = 1'b1;
        count_d        = count_q + CNT_W'(1);
        state_d        = S_DONE;
      end
      S_SEARCH: begin
        priority if (rd_val == val_q) begin
          state_d = S_DONE;
        end else if ((found_q + CNT_W'(1)) >= count_q || rd_link == NULL_LNK) begin
          status_d = ST_NOTFOUND;
          found_d  = '0;
          state_d  = S_DONE;
        end else begin
          cur_d        = rd_link;
          node_raddr_o = rd_link[SLOT_W-1:0];
          found_d      = found_q + CNT_W'(1);
        end
      end
      S_DONE: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      head_q  <= NULL_LNK;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    cur_q      <= cur_d;
    prev_q     <= prev_d;
    prev_val_q <= prev_val_d;
    rem_q      <= rem_d;
    slot_q     <= slot_d;
    link_q     <= link_d;
    val_q      <= val_d;
    status_q   <= status_d;
    removed_q  <= removed_d;
    found_q    <= found_d;
  end

  assign res_o.status         = status_q;
  assign res_o.removed_value  = removed_q;
  assign res_o.found_position = FOUND_W'(found_q);
  assign res_o.item_count     = CNT_OUT_W'(count_q);

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FULL_CNT)
    else $error("item count above slot count");

  a_head_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) == (head_q == NULL_LNK))
    else $error("head link disagrees with item count");

  a_pop_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_req_o.pop |-> count_q < FULL_CNT)
    else $error("free slot taken from a full list");

  a_push_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_req_o.push |=> count_q == $past(count_q) - CNT_W'(1))
    else $error("slot returned without count decrement");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && status_q != ST_OK) |-> (removed_q == '0 && found_q == '0))
    else $error("failed command carries a value or position");

endmodule

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for array_linked_list_store. Insert, remove, search and
// clear commands go in over a valid/stall port with random gaps on both sides.
// A slot-array copy of the list with its own free queue predicts every result,
// and each result transfer is checked field by field against the oldest
// prediction.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import alls_pkg::*;

  localparam int NSLOT          = 64;
  localparam int NIL            = NSLOT;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 80;

  logic                        clk_i = 1'b0;
  logic                        rst_ni;
  logic                        in_valid_i = 1'b0;
  logic                        in_stall_o;
  logic [1:0]                  command_i = CMD_INSERT;
  logic [POS_W-1:0]            position_i = '0;
  logic signed [IN_VAL_W-1:0]  item_value_i = '0;
  logic                        out_valid_o;
  logic                        out_stall_i = 1'b0;
  logic [STAT_W-1:0]           status_o;
  logic signed [REM_VAL_W-1:0] removed_value_o;
  logic [FOUND_W-1:0]          found_position_o;
  logic [CNT_OUT_W-1:0]        item_count_o;

  // list copy: values and next links per slot, queue of free slots
  logic [31:0] slot_val  [NSLOT];
  logic [6:0]  slot_next [NSLOT];
  logic [5:0]  free_fifo [NSLOT];
  logic [5:0]  free_rd;
  logic [5:0]  free_wr;
  logic [6:0]  head;
  logic [6:0]  live_count;

  result_t expected_results [$];
  result_t want_now;
  logic    calm = 1'b0;
  int      mismatches = 0;
  int      n_sent = 0;
  int      n_checked = 0;
  int      n_full = 0;
  int      n_hits = 0;
  int      peak = 0;
  int      stall_hold = 0;
  int      idle_cycles = 0;

  array_linked_list_store u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .command_i        (command_i),
    .position_i       (position_i),
    .item_value_i     (item_value_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .status_o         (status_o),
    .removed_value_o  (removed_value_o),
    .found_position_o (found_position_o),
    .item_count_o     (item_count_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic void list_reset();
    for (int i = 0; i < NSLOT; i++) begin
      slot_val[i]  = '0;
      slot_next[i] = 7'(NIL);
      free_fifo[i] = 6'(i);
    end
    free_rd    = '0;
    free_wr    = '0;
    head       = 7'(NIL);
    live_count = '0;
  endfunction

  function automatic result_t apply_command(cmd_e cmd, logic [6:0] pos, logic [31:0] val);
    result_t r;
    int      slot;
    int      prev;
    int      cur;
    int      nxt;
    int      k;
    logic    hit;
    r        = '0;
    r.status = ST_OK;
    hit      = 1'b0;
    case (cmd)
      CMD_INSERT: begin
        if (live_count >= NSLOT) begin
          r.status = ST_FULL;
        end else if (pos > live_count) begin
          r.status = ST_BADPOS;
        end else begin
          slot           = free_fifo[free_rd];
          free_rd        = free_rd + 1'b1;
          slot_val[slot] = val;
          if (head >= NSLOT) begin
            head            = 7'(slot);
            slot_next[slot] = 7'(NIL);
          end else if (pos == 0) begin
            slot_next[slot] = head;
            head            = 7'(slot);
          end else begin
            prev = head;
            for (k = 0; k < pos - 1 && prev < NSLOT; k++) prev = slot_next[prev];
            if (prev < NSLOT) begin
              slot_next[slot] = slot_next[prev];
              slot_next[prev] = 7'(slot);
            end else begin
              slot_next[slot] = 7'(NIL);
            end
          end
          live_count = live_count + 1'b1;
        end
      end
      CMD_REMOVE: begin
        if (live_count == 0 || head >= NSLOT) begin
          r.status = ST_EMPTY;
        end else if (pos >= live_count) begin
          r.status = ST_BADPOS;
        end else begin
          prev = NIL;
          cur  = head;
          for (k = 0; k < pos && cur < NSLOT; k++) begin
            prev = cur;
            cur  = slot_next[cur];
          end
          if (cur >= NSLOT) begin
            r.status = ST_BADPOS;
          end else begin
            r.removed_value = slot_val[cur];
            nxt             = slot_next[cur];
            if (prev >= NSLOT) head = 7'(nxt);
            else slot_next[prev] = 7'(nxt);
            free_fifo[free_wr] = 6'(cur);
            free_wr            = free_wr + 1'b1;
            slot_next[cur]     = 7'(NIL);
            slot_val[cur]      = '0;
            live_count         = live_count - 1'b1;
          end
        end
      end
      CMD_SEARCH: begin
        r.status = ST_NOTFOUND;
        cur      = head;
        for (k = 0; k < live_count && cur < NSLOT && !hit; k++) begin
          if (slot_val[cur] == val) begin
            hit              = 1'b1;
            r.status         = ST_OK;
            r.found_position = FOUND_W'(k);
          end else begin
            cur = slot_next[cur];
          end
        end
      end
      default: list_reset();
    endcase
    if (r.status != ST_OK) begin
      r.removed_value  = '0;
      r.found_position = '0;
    end
    r.item_count = live_count;
    return r;
  endfunction

  function automatic logic [31:0] value_at(int p);
    int cur;
    cur = head;
    repeat (p) cur = slot_next[cur];
    return slot_val[cur];
  endfunction

  // mostly no pause, some short, a few long
  function automatic int pause_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(16, 50);
  endfunction

  task automatic send_cmd(cmd_e cmd, int pos, logic [31:0] val);
    int      gap;
    result_t want;
    gap = calm ? 0 : pause_len();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    command_i    <= cmd;
    position_i   <= pos[6:0];
    item_value_i <= val;
    do @(posedge clk_i); while (!(in_valid_i && !in_stall_o));
    want = apply_command(cmd, pos[6:0], val);
    expected_results.push_back(want);
    n_sent++;
    if (want.status == ST_FULL) n_full++;
    if (cmd == CMD_SEARCH && want.status == ST_OK) n_hits++;
    if (live_count > peak) peak = live_count;
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  task automatic test_empty_list();
    send_cmd(CMD_SEARCH, 0, 32'h0000_0000);
    send_cmd(CMD_REMOVE, 0, 32'h0000_0000);
    send_cmd(CMD_REMOVE, 127, 32'hFFFF_FFFF);
    send_cmd(CMD_INSERT, 1, 32'h1234_5678);
    send_cmd(CMD_INSERT, 127, 32'hFFFF_FFFF);
    settle();
  endtask

  task automatic test_edits();
    send_cmd(CMD_INSERT, 0, 32'h7FFF_FFFF);
    send_cmd(CMD_INSERT, 1, 32'h8000_0000);
    send_cmd(CMD_INSERT, 1, 32'h0000_0000);
    send_cmd(CMD_INSERT, 0, 32'hFFFF_FFFF);
    send_cmd(CMD_INSERT, 4, 32'h7FFF_FFFF);
    send_cmd(CMD_SEARCH, 0, 32'h8000_0000);
    // duplicate value, first position wins
    send_cmd(CMD_SEARCH, 0, 32'h7FFF_FFFF);
    send_cmd(CMD_SEARCH, 0, 32'h5555_AAAA);
    send_cmd(CMD_INSERT, 6, 32'h0000_0001);
    send_cmd(CMD_REMOVE, 5, 32'h0000_0000);
    send_cmd(CMD_REMOVE, 2, 32'h0000_0000);
    send_cmd(CMD_REMOVE, 3, 32'h0000_0000);
    send_cmd(CMD_REMOVE, 0, 32'h0000_0000);
    send_cmd(CMD_SEARCH, 0, 32'h8000_0000);
    send_cmd(CMD_CLEAR, 0, 32'h0000_0000);
    send_cmd(CMD_SEARCH, 0, 32'h0000_0000);
    send_cmd(CMD_REMOVE, 0, 32'h0000_0000);
    settle();
  endtask

  task automatic test_fill_and_drain();
    while (live_count < NSLOT) send_cmd(CMD_INSERT, $urandom_range(0, live_count), $urandom);
    send_cmd(CMD_INSERT, 0, $urandom);
    send_cmd(CMD_INSERT, NSLOT, $urandom);
    send_cmd(CMD_SEARCH, 0, value_at(NSLOT - 1));
    while (live_count > 0) send_cmd(CMD_REMOVE, $urandom_range(0, live_count - 1), $urandom);
    send_cmd(CMD_REMOVE, 0, $urandom);
    settle();
  endtask

  task automatic test_random_traffic(int n);
    int          i;
    int          ins_pct;
    int          r;
    int          pos;
    logic [31:0] val;
    cmd_e        cmd;
    ins_pct = 55;
    for (i = 0; i < n; i++) begin
      // each stretch either grows or shrinks the list, some with no pauses
      if (i % 50 == 0) begin
        calm    = ($urandom_range(0, 3) == 0);
        ins_pct = $urandom_range(0, 1) ? 55 : 25;
      end
      r   = $urandom_range(0, 99);
      val = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 7) : $urandom;
      pos = $urandom_range(0, live_count);
      if (r < ins_pct) begin
        cmd = CMD_INSERT;
      end else if (r < 75) begin
        cmd = CMD_REMOVE;
        if (live_count != 0) pos = $urandom_range(0, live_count - 1);
      end else if (r < 97) begin
        cmd = CMD_SEARCH;
        if (live_count != 0 && $urandom_range(0, 2) != 0)
          val = value_at($urandom_range(0, live_count - 1));
      end else begin
        cmd = CMD_CLEAR;
      end
      if ($urandom_range(0, 9) == 0) pos = $urandom_range(0, 127);
      send_cmd(cmd, pos, val);
    end
    calm = 1'b0;
    settle();
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_hold  <= 0;
    end else if (stall_hold > 0) begin
      stall_hold <= stall_hold - 1;
    end else begin
      out_stall_i <= !calm && ($urandom_range(0, 2) == 0);
      stall_hold  <= pause_len();
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        $display("%0t ns: result transfer with nothing pending, status %0d count %0d",
                 $time, status_o, item_count_o);
        mismatches++;
      end else begin
        want_now = expected_results.pop_front();
        n_checked++;
        check_field("status", want_now.status, status_o);
        check_field("removed_value", want_now.removed_value, removed_value_o);
        check_field("found_position", want_now.found_position, found_position_o);
        check_field("item_count", want_now.item_count, item_count_o);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t ns: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("FAIL array_linked_list_store");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    rst_ni = 1'b0;
    list_reset();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_list();
    test_edits();
    test_fill_and_drain();
    test_random_traffic(500);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("%0d commands sent, %0d results checked, %0d search hits", n_sent, n_checked,
             n_hits);
    $display("list held up to %0d items, %0d inserts refused as full", peak, n_full);
    if (mismatches == 0) begin
      $display("PASS array_linked_list_store");
    end else begin
      $display("FAIL array_linked_list_store");
    end
    $finish;
  end

endmodule
